// ----- sv/hvr_pkg.sv -----
// ----------------------------------------------------------------------------
// hvr_pkg
// Shared types, constants and helper functions of the velocity ramp unit.
// ----------------------------------------------------------------------------
package hvr_pkg;

    // Field widths
    localparam int VEL_W   = 24;
    localparam int ANG_W   = 16;
    localparam int TIME_W  = 32;
    localparam int DT_W    = 20;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 8;

    // Arithmetic widths
    localparam int CS_W    = 19;   // CORDIC x/y
    localparam int MA_W    = 33;   // multiplier operand a
    localparam int MB_W    = 26;   // multiplier operand b
    localparam int PROD_W  = MA_W + MB_W;
    localparam int QUO_W   = 25;
    localparam int NUM_W   = TIME_W + QUO_W;

    // CORDIC
    localparam int CORDIC_STEPS = 14;
    localparam int STEP_W       = 4;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN = 19'sd39797;

    // Defaults
    localparam int unsigned ALIGN_TOL_DEF = 182;
    localparam logic [TIME_W-1:0] RAMP_RESET = 32'd1000000;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_SPEED = 8'd0;
    localparam logic [IDX_W-1:0] CFG_DIR   = 8'd1;
    localparam logic [IDX_W-1:0] CFG_RAMP  = 8'd2;
    localparam logic [IDX_W-1:0] CFG_ROT   = 8'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_CST, S_CORD, S_GX, S_GY, S_GW, S_MUL, S_DLD, S_DIV, S_EMIT
    } t_state;

    typedef enum logic [1:0] {CH_X, CH_Y, CH_W} t_chan;

    // Arctangent of 2^-i in binary angle units.
    function automatic logic signed [ANG_W-1:0] f_atan(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        case (i)
            4'd0:    v = 16'sd8192;
            4'd1:    v = 16'sd4836;
            4'd2:    v = 16'sd2555;
            4'd3:    v = 16'sd1297;
            4'd4:    v = 16'sd651;
            4'd5:    v = 16'sd326;
            4'd6:    v = 16'sd163;
            4'd7:    v = 16'sd81;
            4'd8:    v = 16'sd41;
            4'd9:    v = 16'sd20;
            4'd10:   v = 16'sd10;
            4'd11:   v = 16'sd5;
            4'd12:   v = 16'sd3;
            4'd13:   v = 16'sd1;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // Round a Q.16 product to nearest and saturate to a velocity.
    function automatic logic signed [VEL_W-1:0] f_round_sat(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        r = (p + 59'sd32768) >>> 16;
        if (r > 59'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (r < -59'sd8388608) begin
            return 24'sh800000;
        end
        return r[VEL_W-1:0];
    endfunction

endpackage

// ----- sv/hvr_cordic.sv -----
// ----------------------------------------------------------------------------
// hvr_cordic
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, then
// quadrant mapping to cosine and sine.
// ----------------------------------------------------------------------------
module hvr_cordic
    import hvr_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [ANG_W-1:0]       i_angle,
    output logic                   o_done,
    output logic signed [CS_W-1:0] o_cos,
    output logic signed [CS_W-1:0] o_sin
);

    logic signed [CS_W-1:0]  r_x, r_y;
    logic signed [ANG_W-1:0] r_z;
    logic [1:0]              r_quad;
    logic [STEP_W-1:0]       r_step;
    logic                    r_busy;
    logic                    r_done;
    logic signed [CS_W-1:0]  dx, dy;

    // Shifted terms of the current micro-rotation.
    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;

    // Rotation sequence.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= {2'b00, i_angle[ANG_W-3:0]};
                r_quad <= i_angle[ANG_W-1:ANG_W-2];
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!r_z[ANG_W-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - f_atan(r_step);
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + f_atan(r_step);
                end
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_step <= r_step + 1'b1;
            end
        end
    end

    // Map the first-quadrant result back to the full circle.
    always_comb begin
        case (r_quad)
            2'd0:    begin o_cos = r_x;  o_sin = r_y;  end
            2'd1:    begin o_cos = -r_y; o_sin = r_x;  end
            2'd2:    begin o_cos = -r_x; o_sin = -r_y; end
            default: begin o_cos = r_y;  o_sin = -r_x; end
        endcase
    end

    assign o_done = r_done;

endmodule

// ----- sv/hvr_div.sv -----
// ----------------------------------------------------------------------------
// hvr_div
// Restoring divider, one quotient bit per cycle. The numerator is known to
// give a quotient that fits QUO_W bits.
// ----------------------------------------------------------------------------
module hvr_div
    import hvr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [TIME_W-1:0] i_den,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quo
);

    logic [TIME_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_q;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TIME_W:0]   w_trial;
    logic              w_ge;

    // Trial subtract of the next partial remainder.
    assign w_trial = {r_rem, r_q[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num[NUM_W-1:QUO_W];
                r_q    <= i_num[QUO_W-1:0];
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? TIME_W'(w_trial - {1'b0, i_den}) : w_trial[TIME_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], w_ge};
                if (r_cnt == 5'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;

endmodule

// ----- sv/holonomic_velocity_ramp_unit.sv -----
// ----------------------------------------------------------------------------
// holonomic_velocity_ramp_unit
// Velocity ramp generator for a holonomic base with a shared multiplier,
// an iterative divider and an iterative CORDIC under one sequencer.
// ----------------------------------------------------------------------------
// Command (register write): setup, CORDIC, then multiplies for x and y targets.
// Tick while ramping: per channel a multiply, a divider load and a divide (no
// angular channel when aligned), then emit; held or idle ticks go to emit.
// A result leaves through an output register; the next item may enter then.
// Synchronous active-low reset clears control registers; ramp time resets to 1 s.
module holonomic_velocity_ramp_unit
    import hvr_pkg::*;
#(
    parameter int unsigned ALIGN_TOL = ALIGN_TOL_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [DT_W-1:0]         i_dt_us,
    input  logic [ANG_W-1:0]        i_heading,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VEL_W-1:0] o_vel_x,
    output logic signed [VEL_W-1:0] o_vel_y,
    output logic signed [VEL_W-1:0] o_omega,
    output logic                    o_ramping,
    output logic                    o_aligned
);

    t_state r_state, n_state;

    // Configuration and command state
    logic signed [VEL_W-1:0] r_speed, r_rot;
    logic [ANG_W-1:0]        r_dir;
    logic [TIME_W-1:0]       r_ramp;
    logic signed [VEL_W-1:0] r_cur_vx, r_cur_vy, r_cur_w;
    logic signed [VEL_W-1:0] r_st_vx, r_st_vy, r_st_w;
    logic signed [VEL_W-1:0] r_goal_vx, r_goal_vy;
    logic [TIME_W-1:0]       r_elapsed;
    logic                    r_cmd;

    // Per-item working registers
    logic [TIME_W-1:0]       r_t, r_tden;
    logic signed [VEL_W-1:0] r_wf;
    logic                    r_ramping, r_aligned, r_qneg;
    t_chan                   r_ch;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_ovalid;

    logic cmd_wr, in_acc, out_acc, emit;
    logic cord_start, cord_done, div_start, div_done;
    logic signed [CS_W-1:0]  cord_cos, cord_sin;
    logic [QUO_W-1:0]        div_quo;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic [NUM_W-1:0]        div_num;

    // Tick decode
    logic [ANG_W-1:0]        herr;
    logic                    herr_neg, aligned_c, ramping_c, inramp_c;
    logic [ANG_W-1:0]        aerr;
    logic [TIME_W-1:0]       tden_c;
    logic [TIME_W:0]         tsum;
    logic signed [VEL_W:0]   mag_c;
    logic signed [VEL_W-1:0] mag_sat, wf_c;
    logic signed [VEL_W:0]   diff;
    logic signed [QUO_W:0]   q_s;
    logic signed [VEL_W-1:0] blend_v, st_sel;

    assign cmd_wr  = i_cfg_we && (i_cfg_idx <= CFG_ROT);
    assign in_acc  = i_in_valid && (r_state == S_IDLE);
    assign out_acc = r_ovalid && !i_out_stall;
    assign emit    = (r_state == S_EMIT) && (!r_ovalid || !i_out_stall);

    // Heading error, alignment and ramp status of the arriving tick.
    assign herr      = r_dir - i_heading;
    assign herr_neg  = herr[ANG_W-1];
    assign aerr      = herr_neg ? ANG_W'(~herr + 1'b1) : herr;
    assign aligned_c = aerr < ANG_W'(ALIGN_TOL);
    assign ramping_c = r_cmd && (r_elapsed != '0);
    assign tden_c    = (r_ramp == '0) ? TIME_W'(1) : r_ramp;
    assign inramp_c  = r_elapsed <= tden_c;
    assign tsum      = {1'b0, r_elapsed} + {{(TIME_W-DT_W+1){1'b0}}, i_dt_us};
    assign mag_c     = r_rot[VEL_W-1] ? -(VEL_W+1)'(r_rot) : (VEL_W+1)'(r_rot);
    // The magnitude of the most negative rotation rate does not fit and saturates.
    assign mag_sat   = mag_c[VEL_W-1] ? 24'sh7FFFFF : mag_c[VEL_W-1:0];
    assign wf_c      = herr_neg ? -mag_sat : mag_sat;

    // Ramp difference and start value of the channel being blended.
    always_comb begin
        case (r_ch)
            CH_X: begin
                st_sel = r_st_vx;
                diff   = (VEL_W+1)'(r_goal_vx) - (VEL_W+1)'(r_st_vx);
            end
            CH_Y: begin
                st_sel = r_st_vy;
                diff   = (VEL_W+1)'(r_goal_vy) - (VEL_W+1)'(r_st_vy);
            end
            default: begin
                st_sel = r_st_w;
                diff   = (VEL_W+1)'(r_wf) - (VEL_W+1)'(r_st_w);
            end
        endcase
    end

    assign q_s     = r_qneg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign blend_v = VEL_W'((VEL_W+1)'(st_sel) + q_s[VEL_W:0]);
    assign div_num = r_prod[PROD_W-1] ? NUM_W'(-r_prod) : NUM_W'(r_prod);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (cmd_wr) begin
                    n_state = S_CST;
                end else if (in_acc) begin
                    n_state = (ramping_c && inramp_c) ? S_MUL : S_EMIT;
                end
            end
            S_CST:  n_state = S_CORD;
            S_CORD: if (cord_done) n_state = S_GX;
            S_GX:   n_state = S_GY;
            S_GY:   n_state = S_GW;
            S_GW:   n_state = S_IDLE;
            S_MUL:  n_state = S_DLD;
            S_DLD:  n_state = S_DIV;
            S_DIV: begin
                if (div_done) begin
                    if (r_ch == CH_W || (r_ch == CH_Y && r_aligned)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_EMIT: if (emit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs: unit starts and multiplier operands.
    always_comb begin
        cord_start = (r_state == S_CST);
        div_start  = (r_state == S_DLD);
        mul_a      = '0;
        mul_b      = '0;
        case (r_state)
            S_GX: begin
                mul_a = MA_W'(cord_cos);
                mul_b = MB_W'(r_speed);
            end
            S_GY: begin
                mul_a = MA_W'(cord_sin);
                mul_b = MB_W'(r_speed);
            end
            S_MUL: begin
                mul_a = $signed({1'b0, r_t});
                mul_b = MB_W'(diff);
            end
            default: ;
        endcase
    end

    // Shared multiplier with registered product.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (r_state == S_DLD) begin
            r_qneg <= r_prod[PROD_W-1];
        end
    end

    // State, configuration and velocity registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_speed   <= '0;
            r_dir     <= '0;
            r_ramp    <= RAMP_RESET;
            r_rot     <= '0;
            r_cur_vx  <= '0;
            r_cur_vy  <= '0;
            r_cur_w   <= '0;
            r_st_vx   <= '0;
            r_st_vy   <= '0;
            r_st_w    <= '0;
            r_goal_vx <= '0;
            r_goal_vy <= '0;
            r_elapsed <= '0;
            r_cmd     <= 1'b0;
            r_ch      <= CH_X;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // A register write to indexes up to CFG_ROT issues a command.
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SPEED: r_speed <= i_cfg_data[VEL_W-1:0];
                    CFG_DIR:   r_dir   <= i_cfg_data[ANG_W-1:0];
                    CFG_RAMP:  r_ramp  <= i_cfg_data[TIME_W-1:0];
                    CFG_ROT:   r_rot   <= i_cfg_data[VEL_W-1:0];
                    default: ;
                endcase
            end
            if (cmd_wr) begin
                r_st_vx   <= r_cur_vx;
                r_st_vy   <= r_cur_vy;
                r_st_w    <= r_cur_w;
                r_elapsed <= '0;
                r_cmd     <= 1'b1;
            end

            // Targets from the CORDIC results.
            if (r_state == S_GY) r_goal_vx <= f_round_sat(r_prod);
            if (r_state == S_GW) r_goal_vy <= f_round_sat(r_prod);

            // Tick acceptance: latch time, decide held or ramped values.
            if (in_acc && !cmd_wr) begin
                r_t       <= r_elapsed;
                r_tden    <= tden_c;
                r_elapsed <= tsum[TIME_W] ? '1 : tsum[TIME_W-1:0];
                r_ramping <= ramping_c;
                r_aligned <= aligned_c;
                r_wf      <= wf_c;
                r_ch      <= CH_X;
                if (ramping_c) begin
                    if (!inramp_c) begin
                        r_cur_vx <= r_goal_vx;
                        r_cur_vy <= r_goal_vy;
                        r_cur_w  <= aligned_c ? '0 : wf_c;
                    end else if (aligned_c) begin
                        r_cur_w <= '0;
                    end
                end
            end

            // Blended channel result.
            if (r_state == S_DIV && div_done) begin
                case (r_ch)
                    CH_X:    r_cur_vx <= blend_v;
                    CH_Y:    r_cur_vy <= blend_v;
                    default: r_cur_w  <= blend_v;
                endcase
                r_ch <= (r_ch == CH_X) ? CH_Y : CH_W;
            end

            // Output register.
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (out_acc) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_vel_x   <= r_cur_vx;
            o_vel_y   <= r_cur_vy;
            o_omega   <= r_cur_w;
            o_ramping <= r_ramping;
            o_aligned <= r_aligned;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;

    hvr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_angle (r_dir),
        .o_done  (cord_done),
        .o_cos   (cord_cos),
        .o_sin   (cord_sin)
    );

    hvr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_tden),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

endmodule

// ----- sv/hvr_checker.sv -----
// ----------------------------------------------------------------------------
// hvr_checker
// Port-level checks of the velocity ramp unit, bound to the top level.
// ----------------------------------------------------------------------------
module hvr_checker
    import hvr_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_we,
    input logic [IDX_W-1:0]        i_cfg_idx,
    input logic                    i_in_valid,
    input logic                    o_in_stall,
    input logic                    o_out_valid,
    input logic                    i_out_stall,
    input logic signed [VEL_W-1:0] o_omega,
    input logic                    o_ramping,
    input logic                    o_aligned
);

    // No result is offered right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && $past(i_rst_n) == 1'b0 |-> !o_out_valid)
        else $error("result valid right after reset");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_omega))
        else $error("stalled result dropped or changed");

    // An aligned heading during a ramp commands no rotation.
    a_aligned_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ramping && o_aligned |-> o_omega == '0)
        else $error("nonzero omega while aligned");

    // An accepted item keeps the unit busy for the next cycle.
    a_item_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !i_cfg_we |=> o_in_stall)
        else $error("unit free right after accepting an item");

    // A command write starts target computation.
    a_cmd_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && !o_in_stall && i_cfg_idx <= CFG_ROT |=> o_in_stall)
        else $error("unit free right after a command");

endmodule

bind holonomic_velocity_ramp_unit hvr_checker u_hvr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_omega     (o_omega),
    .o_ramping   (o_ramping),
    .o_aligned   (o_aligned)
);
